[design/hist_pkg.sv]
// Shared types, constants and helpers for the RGB channel histogram.
package hist_pkg;

  localparam int BIN_COUNT   = 256;
  localparam int COUNT_WIDTH = 24;
  localparam int BIN_AW      = $clog2(BIN_COUNT);
  localparam int OUT_WIDTH   = 24;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [BIN_AW-1:0]      bin_addr_t;
  typedef logic [OUT_WIDTH-1:0]   out_count_t;

  localparam count_t COUNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_READ  = 2'd2
  } mode_t;

  // Operation applied to a channel by the item in the update stage.
  typedef struct packed {
    logic clear;
    logic add;
  } hist_ctl_t;

  // Fit a count to the output width: zero-extend or keep the low bits.
  function automatic out_count_t to_out(input count_t c);
    logic [31:0] wide;
    wide = 32'(c);
    return wide[OUT_WIDTH-1:0];
  endfunction

endpackage

[design/hist_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module hist_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/hist_channel.sv]
// One channel of bins: RAM, per-bin valid bits, forwarding and saturating increment.
module hist_channel (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  acc_en,
  input  hist_pkg::bin_addr_t   acc_addr,
  input  hist_pkg::hist_ctl_t   ctl,
  output hist_pkg::count_t      count
);

  hist_pkg::bin_addr_t          addr_r;
  hist_pkg::count_t             rdata;
  hist_pkg::count_t             cur;
  hist_pkg::count_t             upd;
  logic [hist_pkg::BIN_COUNT-1:0] valid_r;
  logic                         wr_en_r;
  hist_pkg::bin_addr_t          wr_addr_r;
  hist_pkg::count_t             wr_data_r;
  logic                         fwd_hit;

  hist_ram #(
    .WIDTH(hist_pkg::COUNT_WIDTH),
    .DEPTH(hist_pkg::BIN_COUNT)
  ) u_ram (
    .clk  (clk),
    .we   (ctl.add),
    .waddr(addr_r),
    .wdata(upd),
    .re   (acc_en),
    .raddr(acc_addr),
    .rdata(rdata)
  );

  // Hold the address of the item now in the update stage.
  always_ff @(posedge clk) begin
    if (acc_en) begin
      addr_r <= acc_addr;
    end
  end

  // The read issued alongside last cycle's write misses that write: forward it.
  assign fwd_hit = wr_en_r && (wr_addr_r == addr_r);

  always_comb begin
    if (fwd_hit) begin
      cur = wr_data_r;
    end else if (valid_r[addr_r]) begin
      cur = rdata;
    end else begin
      cur = '0;
    end
    upd = (cur == hist_pkg::COUNT_MAX) ? cur : cur + hist_pkg::count_t'(1);
  end

  assign count = cur;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      wr_en_r <= 1'b0;
    end else begin
      wr_en_r <= ctl.add;
      if (ctl.clear) begin
        valid_r <= '0;
      end else if (ctl.add) begin
        valid_r[addr_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r <= addr_r;
    wr_data_r <= upd;
  end

endmodule

[design/rgb_channel_histogram_core.sv]
// Top level of the RGB channel histogram: three bin channels and the item pipeline.
//
// The block takes one item in every clock cycle and never raises busy. Each item
// passes a two-stage read-modify-write pipeline: at acceptance the bin RAM of each
// channel is read, in the next cycle the count is incremented (saturating) and
// written back. An add that hits the bin written by the item just before it is
// served by forwarding, so back-to-back pixels of the same color count correctly.
// A clear item drops every bin of all three channels at once through per-bin valid
// bits; reset does the same, so there is no clearing sweep and the block is ready
// in the first cycle after reset. A read item yields one result: the request passes
// read_r and then strobe_r, which drives out_strobe; the strobe stays high for exactly
// one cycle per read, and the three counts of the requested bin are registered with it.
// Results cannot be held off; capture them on the strobe.
// Clear, add and the unused mode code give no result.
module rgb_channel_histogram_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_mode,
  input  logic [7:0]                 in_red,
  input  logic [7:0]                 in_green,
  input  logic [7:0]                 in_blue,
  input  logic [7:0]                 in_bin_index,
  output logic                       out_strobe,
  output hist_pkg::out_count_t       out_red_count,
  output hist_pkg::out_count_t       out_green_count,
  output hist_pkg::out_count_t       out_blue_count
);

  logic                accept;
  hist_pkg::hist_ctl_t ctl_nxt;
  hist_pkg::hist_ctl_t ctl_r;
  logic                read_nxt;
  logic                read_r;
  hist_pkg::bin_addr_t red_addr;
  hist_pkg::bin_addr_t green_addr;
  hist_pkg::bin_addr_t blue_addr;
  hist_pkg::count_t    red_cnt;
  hist_pkg::count_t    green_cnt;
  hist_pkg::count_t    blue_cnt;
  logic                strobe_r;
  hist_pkg::out_count_t red_out_r;
  hist_pkg::out_count_t green_out_r;
  hist_pkg::out_count_t blue_out_r;

  // No stall source: every start is taken.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Decode the mode and pick the bin each channel reads at acceptance.
  always_comb begin
    ctl_nxt    = '0;
    read_nxt   = 1'b0;
    red_addr   = hist_pkg::bin_addr_t'(in_red);
    green_addr = hist_pkg::bin_addr_t'(in_green);
    blue_addr  = hist_pkg::bin_addr_t'(in_blue);
    unique case (hist_pkg::mode_t'(in_mode))
      hist_pkg::MODE_CLEAR: ctl_nxt.clear = accept;
      hist_pkg::MODE_ADD:   ctl_nxt.add   = accept;
      hist_pkg::MODE_READ: begin
        read_nxt   = accept;
        red_addr   = hist_pkg::bin_addr_t'(in_bin_index);
        green_addr = hist_pkg::bin_addr_t'(in_bin_index);
        blue_addr  = hist_pkg::bin_addr_t'(in_bin_index);
      end
      default: ;
    endcase
  end

  // Advance the item into the update stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r  <= '0;
      read_r <= 1'b0;
    end else begin
      ctl_r  <= ctl_nxt;
      read_r <= read_nxt;
    end
  end

  hist_channel u_red (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc_en  (accept),
    .acc_addr(red_addr),
    .ctl     (ctl_r),
    .count   (red_cnt)
  );

  hist_channel u_green (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc_en  (accept),
    .acc_addr(green_addr),
    .ctl     (ctl_r),
    .count   (green_cnt)
  );

  hist_channel u_blue (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc_en  (accept),
    .acc_addr(blue_addr),
    .ctl     (ctl_r),
    .count   (blue_cnt)
  );

  // Register the result of a read item; the strobe lasts one cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= read_r;
    end
  end

  always_ff @(posedge clk) begin
    if (read_r) begin
      red_out_r   <= hist_pkg::to_out(red_cnt);
      green_out_r <= hist_pkg::to_out(green_cnt);
      blue_out_r  <= hist_pkg::to_out(blue_cnt);
    end
  end

  assign out_strobe      = strobe_r;
  assign out_red_count   = red_out_r;
  assign out_green_count = green_out_r;
  assign out_blue_count  = blue_out_r;

endmodule

[tb/rgb_channel_histogram_core_tb.sv]
// Self-checking testbench for the RGB channel histogram core.
module rgb_channel_histogram_core_tb;

  // The mode code that no operation uses; the core must ignore it.
  localparam logic [1:0] MODE_UNUSED    = 2'd3;
  // Run of cycles in which neither an item nor a result moves that ends the test as failed.
  localparam int         WATCHDOG_LIMIT = 200;
  // Read results pass the update stage and the output register; idle this long after the last.
  localparam int         TAIL_CYCLES    = 8;
  localparam int         RANDOM_ITEMS   = 950;

  // One command item plus its handling: how long to idle before it, and
  // whether to hold it until every pending read has come back.
  typedef struct {
    logic [1:0]  mode;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  bin_index;
    int unsigned gap;
    bit          drain;
  } hist_item_t;

  typedef struct {
    hist_pkg::out_count_t red;
    hist_pkg::out_count_t green;
    hist_pkg::out_count_t blue;
  } bin_counts_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [1:0]           in_mode = '0;
  logic [7:0]           in_red = '0;
  logic [7:0]           in_green = '0;
  logic [7:0]           in_blue = '0;
  logic [7:0]           in_bin_index = '0;
  logic                 out_strobe;
  hist_pkg::out_count_t out_red_count;
  hist_pkg::out_count_t out_green_count;
  hist_pkg::out_count_t out_blue_count;

  // Items waiting to be driven, and counts owed by reads already accepted.
  hist_item_t  item_queue[$];
  bin_counts_t read_counts_due[$];

  // Shadow histograms kept by the testbench.
  hist_pkg::count_t red_tally[hist_pkg::BIN_COUNT];
  hist_pkg::count_t green_tally[hist_pkg::BIN_COUNT];
  hist_pkg::count_t blue_tally[hist_pkg::BIN_COUNT];

  // Per-frame palette so that adds pile into a few bins.
  logic [7:0] hot_bytes[4];

  logic        took_item = 1'b0;
  int unsigned gap_left = 0;
  bit          head_armed = 1'b0;
  int          quiet_cycles = 0;
  int          errors = 0;

  rgb_channel_histogram_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .in_bin_index    (in_bin_index),
    .out_strobe      (out_strobe),
    .out_red_count   (out_red_count),
    .out_green_count (out_green_count),
    .out_blue_count  (out_blue_count)
  );

  always #1 clk = ~clk;

  // Saturating increment: a full bin keeps its value.
  function automatic hist_pkg::count_t bump_count(input hist_pkg::count_t c);
    if (c == hist_pkg::COUNT_MAX) return c;
    return c + hist_pkg::count_t'(1);
  endfunction

  // Apply one accepted item to the shadow histograms; a read records the
  // counts the core owes, cut to the output width.
  function automatic void tally_item(input logic [1:0] mode, input logic [7:0] red,
                                     input logic [7:0] green, input logic [7:0] blue,
                                     input logic [7:0] bin_index);
    bin_counts_t due;
    if (mode == hist_pkg::MODE_CLEAR) begin
      foreach (red_tally[i]) begin
        red_tally[i]   = '0;
        green_tally[i] = '0;
        blue_tally[i]  = '0;
      end
    end else if (mode == hist_pkg::MODE_ADD) begin
      red_tally[red]     = bump_count(red_tally[red]);
      green_tally[green] = bump_count(green_tally[green]);
      blue_tally[blue]   = bump_count(blue_tally[blue]);
    end else if (mode == hist_pkg::MODE_READ) begin
      due.red   = hist_pkg::out_count_t'(red_tally[bin_index]);
      due.green = hist_pkg::out_count_t'(green_tally[bin_index]);
      due.blue  = hist_pkg::out_count_t'(blue_tally[bin_index]);
      read_counts_due.push_back(due);
    end
  endfunction

  function automatic void check_count(input string name, input hist_pkg::out_count_t want,
                                      input hist_pkg::out_count_t got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  function automatic void queue_item(input logic [1:0] mode, input logic [7:0] red,
                                     input logic [7:0] green, input logic [7:0] blue,
                                     input logic [7:0] bin_index, input int unsigned gap,
                                     input bit drain);
    hist_item_t it;
    it.mode      = mode;
    it.red       = red;
    it.green     = green;
    it.blue      = blue;
    it.bin_index = bin_index;
    it.gap       = gap;
    it.drain     = drain;
    item_queue.push_back(it);
  endfunction

  // Half the time reuse a palette byte, else take any byte.
  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 1) == 1) return hot_bytes[$urandom_range(0, 3)];
    return 8'($urandom);
  endfunction

  // Driver: present items at the falling edge. Hold an item until it is
  // taken; idle for its gap first, and for a draining item wait until no
  // read result is owed any more.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || took_item) begin
      if (item_queue.size() == 0) begin
        start <= 1'b0;
      end else begin
        if (!head_armed) begin
          gap_left   = item_queue[0].gap;
          head_armed = 1'b1;
        end
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (item_queue[0].drain && read_counts_due.size() != 0) begin
          start <= 1'b0;
        end else begin
          in_mode      <= item_queue[0].mode;
          in_red       <= item_queue[0].red;
          in_green     <= item_queue[0].green;
          in_blue      <= item_queue[0].blue;
          in_bin_index <= item_queue[0].bin_index;
          start        <= 1'b1;
          void'(item_queue.pop_front());
          head_armed = 1'b0;
        end
      end
    end
  end

  // Monitor: at the rising edge, tally the accepted item, check any result
  // against the oldest owed counts, and watch for a stalled core.
  always @(posedge clk) begin : monitor
    bin_counts_t want;
    took_item <= rst_n && start && !busy;
    if (rst_n) begin
      if (start && !busy)
        tally_item(in_mode, in_red, in_green, in_blue, in_bin_index);
      if (out_strobe) begin
        if (read_counts_due.size() == 0) begin
          $error("result with no read pending: red %0d green %0d blue %0d",
                 out_red_count, out_green_count, out_blue_count);
          errors++;
        end else begin
          want = read_counts_due.pop_front();
          check_count("red_count", want.red, out_red_count);
          check_count("green_count", want.green, out_green_count);
          check_count("blue_count", want.blue, out_blue_count);
        end
      end
      if ((start && !busy) || out_strobe) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("** rgb_channel_histogram_core: FAILED **");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    int          counted;
    int          frame_len;
    int          roll;
    bit          calm;
    int unsigned gap;

    // Directed: extreme bins, back-to-back adds to one bin, ignored fields,
    // the unused mode, a read right after an add, and a clear.
    queue_item(hist_pkg::MODE_READ,  8'hff, 8'hff, 8'hff, 8'h00, 0, 1'b0);
    queue_item(hist_pkg::MODE_READ,  8'h00, 8'h00, 8'h00, 8'hff, 0, 1'b0);
    queue_item(hist_pkg::MODE_ADD,   8'h00, 8'h00, 8'h00, 8'hff, 0, 1'b0);
    queue_item(hist_pkg::MODE_ADD,   8'hff, 8'hff, 8'hff, 8'h00, 0, 1'b0);
    queue_item(hist_pkg::MODE_ADD,   8'h00, 8'hff, 8'h00, 8'h5a, 0, 1'b0);
    repeat (3) queue_item(hist_pkg::MODE_ADD, 8'd10, 8'd20, 8'd30, 8'h00, 0, 1'b0);
    queue_item(MODE_UNUSED,          8'hff, 8'hff, 8'hff, 8'hff, 0, 1'b0);
    queue_item(MODE_UNUSED,          8'h00, 8'h00, 8'h00, 8'h00, 1, 1'b0);
    queue_item(hist_pkg::MODE_READ,  8'hff, 8'hff, 8'hff, 8'd10, 0, 1'b0);
    queue_item(hist_pkg::MODE_READ,  8'h00, 8'h00, 8'h00, 8'd20, 0, 1'b0);
    queue_item(hist_pkg::MODE_READ,  8'h00, 8'h00, 8'h00, 8'd30, 2, 1'b0);
    queue_item(hist_pkg::MODE_READ,  8'hff, 8'hff, 8'hff, 8'h00, 0, 1'b0);
    queue_item(hist_pkg::MODE_READ,  8'h00, 8'h00, 8'h00, 8'hff, 0, 1'b0);
    queue_item(hist_pkg::MODE_ADD,   8'h55, 8'haa, 8'h55, 8'haa, 0, 1'b0);
    queue_item(hist_pkg::MODE_READ,  8'h00, 8'h00, 8'h00, 8'h55, 0, 1'b0);
    queue_item(hist_pkg::MODE_READ,  8'h00, 8'h00, 8'h00, 8'haa, 0, 1'b0);
    queue_item(hist_pkg::MODE_CLEAR, 8'hff, 8'hff, 8'hff, 8'hff, 3, 1'b1);
    queue_item(hist_pkg::MODE_READ,  8'h00, 8'h00, 8'h00, 8'h00, 0, 1'b0);
    queue_item(hist_pkg::MODE_READ,  8'h00, 8'h00, 8'h00, 8'd10, 0, 1'b0);
    queue_item(hist_pkg::MODE_ADD,   8'd1,  8'd2,  8'd3,  8'h00, 0, 1'b0);
    queue_item(hist_pkg::MODE_READ,  8'h00, 8'h00, 8'h00, 8'd1,  4, 1'b0);

    // Random frames: a clear, then mostly adds into a few hot bins with reads
    // mixed in, a stray clear now and then, and a little unused-mode noise.
    // Some frames run with no idling at all.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 2) == 0);
      foreach (hot_bytes[k]) hot_bytes[k] = 8'($urandom);
      frame_len = $urandom_range(20, 120);
      gap = calm ? 0 : $urandom_range(0, 8);
      queue_item(hist_pkg::MODE_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom), gap, $urandom_range(0, 2) == 0);
      counted++;
      for (int j = 0; j < frame_len; j++) begin
        roll = $urandom_range(0, 99);
        gap  = calm ? 0 : $urandom_range(0, 8);
        if (roll < 3) begin
          queue_item(MODE_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     gap, 1'b0);
        end else begin
          if (roll < 5)
            queue_item(hist_pkg::MODE_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom),
                       8'($urandom), gap, 1'b0);
          else if (roll < 25)
            queue_item(hist_pkg::MODE_READ, 8'($urandom), 8'($urandom), 8'($urandom),
                       pick_byte(), gap, 1'b0);
          else
            queue_item(hist_pkg::MODE_ADD, pick_byte(), pick_byte(), pick_byte(),
                       8'($urandom), gap, 1'b0);
          counted++;
        end
      end
    end

    // Release reset at a falling edge; it is never asserted again.
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Hold until every item is taken and every owed result has come.
    while (item_queue.size() != 0 || start || read_counts_due.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (errors == 0)
      $display("** rgb_channel_histogram_core: PASSED **");
    else
      $display("** rgb_channel_histogram_core: FAILED **");
    $finish;
  end

endmodule
